// ===== src/wds_pkg.sv =====
// ----------------------------------------------------------------------------
// wds_pkg
// shared widths, constants and beat types of the 2d wilson dirac stencil
// ----------------------------------------------------------------------------
package wds_pkg;

   localparam int SITE_W        = 10;
   localparam int DATA_W        = 32;
   localparam int SIGN_W        = 4;
   localparam int CPLX_W        = 2 * DATA_W;
   localparam int MEM_DEPTH     = 1024;
   localparam int NB_NUM        = 4;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_IDX_W     = 1;
   localparam int LATTICE_X_DEF = 32;
   localparam int LATTICE_T_DEF = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MASS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'b1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic [SITE_W-1:0]        site;
      logic signed [DATA_W-1:0] link_t_re;
      logic signed [DATA_W-1:0] link_t_im;
      logic signed [DATA_W-1:0] link_x_re;
      logic signed [DATA_W-1:0] link_x_im;
      logic signed [DATA_W-1:0] up_re;
      logic signed [DATA_W-1:0] up_im;
      logic signed [DATA_W-1:0] down_re;
      logic signed [DATA_W-1:0] down_im;
      logic [SIGN_W-1:0]        hop_signs;
   } req_type;

   typedef struct packed {
      logic [SITE_W-1:0]        out_site;
      logic signed [DATA_W-1:0] res_up_re;
      logic signed [DATA_W-1:0] res_up_im;
      logic signed [DATA_W-1:0] res_down_re;
      logic signed [DATA_W-1:0] res_down_im;
      logic                     saturated;
   } rsp_type;

   // one classified item handed from front to back
   typedef struct packed {
      req_type                        item;
      logic [NB_NUM-1:0][SITE_W-1:0]  nb;
   } job_type;

endpackage

// ===== src/wds_ram.sv =====
// ----------------------------------------------------------------------------
// wds_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module wds_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/wds_front.sv =====
// ----------------------------------------------------------------------------
// wds_front
// accepts request beats, drops sites off the lattice, finds the four neighbors
// ----------------------------------------------------------------------------
module wds_front #(
   parameter int LATTICE_X = wds_pkg::LATTICE_X_DEF,
   parameter int LATTICE_T = wds_pkg::LATTICE_T_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wds_pkg::req_type req_data,
   output logic             q_push,
   input  logic             q_full,
   output wds_pkg::job_type q_data
);

   localparam int TOTAL    = LATTICE_X * LATTICE_T;
   localparam int NB_W     = 18;
   localparam int RECIP_SH = 20;
   localparam int RECIP_W  = 20;
   localparam int RECIP    = ((2 ** RECIP_SH) + LATTICE_T - 1) / LATTICE_T;
   localparam int PROD_W   = wds_pkg::SITE_W + RECIP_W;
   localparam int T_W      = $clog2(LATTICE_T);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_MOD, F_PUSH} state_type;

   state_type                   state_ff;
   wds_pkg::req_type            item_ff;
   logic [wds_pkg::SITE_W-1:0]  quo_ff;
   logic [wds_pkg::SITE_W-1:0]  quo_in;
   logic [T_W-1:0]              t_ff;
   logic [T_W-1:0]              t_in;
   logic [PROD_W-1:0]           div_prod;
   logic [NB_W-1:0]             site_w;
   logic [NB_W-1:0]             xlt;
   logic [NB_W-1:0]             rem;
   logic [NB_W-1:0]             nb0;
   logic [NB_W-1:0]             nb1;
   logic [NB_W-1:0]             nb2;
   logic [NB_W-1:0]             nb3;
   logic                        in_range;

   assign in_range = NB_W'(req_data.site) < NB_W'(TOTAL);
   assign site_w   = NB_W'(item_ff.site);

   // site / LATTICE_T by reciprocal, exact for 10 bit sites
   assign div_prod = PROD_W'(item_ff.site) * PROD_W'(RECIP);
   assign quo_in   = div_prod[PROD_W-1:RECIP_SH];
   assign xlt      = NB_W'(quo_ff) * NB_W'(LATTICE_T);
   assign rem      = site_w - xlt;
   assign t_in     = rem[T_W-1:0];

   always_comb begin
      nb0 = (t_ff == T_W'(LATTICE_T - 1)) ? site_w - NB_W'(LATTICE_T - 1)
                                          : site_w + NB_W'(1);
      nb2 = (t_ff == '0) ? site_w + NB_W'(LATTICE_T - 1) : site_w - NB_W'(1);
      nb1 = (site_w >= NB_W'(TOTAL - LATTICE_T)) ? site_w + NB_W'(LATTICE_T) - NB_W'(TOTAL)
                                                 : site_w + NB_W'(LATTICE_T);
      nb3 = (site_w < NB_W'(LATTICE_T)) ? site_w + NB_W'(TOTAL) - NB_W'(LATTICE_T)
                                        : site_w - NB_W'(LATTICE_T);
   end

   always_comb begin
      q_data.item  = item_ff;
      q_data.nb[0] = nb0[wds_pkg::SITE_W-1:0];
      q_data.nb[1] = nb1[wds_pkg::SITE_W-1:0];
      q_data.nb[2] = nb2[wds_pkg::SITE_W-1:0];
      q_data.nb[3] = nb3[wds_pkg::SITE_W-1:0];
   end

   assign req_stall = (state_ff != F_IDLE);
   assign q_push    = (state_ff == F_PUSH) && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               item_ff <= req_data;
               if (req_valid && in_range) begin
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               quo_ff   <= quo_in;
               state_ff <= F_MOD;
            end
            F_MOD: begin
               t_ff     <= t_in;
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/wds_queue.sv =====
// ----------------------------------------------------------------------------
// wds_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module wds_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  wds_pkg::job_type push_data,
   input  logic             pop,
   output logic             empty,
   output wds_pkg::job_type pop_data
);

   localparam int PTR_W = $clog2(wds_pkg::QUEUE_DEPTH);

   wds_pkg::job_type  entry_ff [wds_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W:0]    count_ff;

   assign full     = (count_ff == (PTR_W + 1)'(wds_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(wds_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(wds_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/wds_back.sv =====
// ----------------------------------------------------------------------------
// wds_back
// site memories, neighbor fetch, complex multiply-accumulate and rounding
// ----------------------------------------------------------------------------
module wds_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   output logic                        q_pop,
   input  wds_pkg::job_type            q_data,
   input  logic signed [wds_pkg::DATA_W-1:0] mass,
   input  logic                        mode,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output wds_pkg::rsp_type            rsp_data
);

   localparam int OP_W        = wds_pkg::DATA_W + 1;
   localparam int FULL_W      = 2 * OP_W;
   localparam int PROD_W      = 58;
   localparam int ACC_W       = 60;
   localparam int V_W         = ACC_W - 17;
   localparam int FETCH_STEPS = 5;
   localparam int MUL_STEPS   = 10;
   localparam int SPIN_N      = 5;
   localparam int SP_W        = $clog2(SPIN_N);
   localparam int AW          = $clog2(wds_pkg::MEM_DEPTH);

   localparam logic [1:0] ROT_P1 = 2'd0;
   localparam logic [1:0] ROT_PI = 2'd1;
   localparam logic [1:0] ROT_M1 = 2'd2;
   localparam logic [1:0] ROT_MI = 2'd3;

   localparam logic signed [V_W-1:0]   V_MAX = V_W'(64'sd2147483647);
   localparam logic signed [V_W-1:0]   V_MIN = ~V_MAX;
   localparam logic signed [ACC_W-1:0] RND   = ACC_W'(65536);
   localparam logic signed [OP_W-1:0]  TWO_Q = OP_W'(33554432);

   typedef enum logic [2:0] {B_IDLE, B_LOAD, B_FETCH, B_MUL, B_FIN} state_type;

   typedef struct packed {
      logic signed [OP_W-1:0] re;
      logic signed [OP_W-1:0] im;
   } cxo_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] im;
   } cxa_type;

   typedef struct packed {
      logic                             sat;
      logic signed [wds_pkg::DATA_W-1:0] val;
   } fin_type;

   function automatic cxa_type rot(input cxa_type z, input logic [1:0] code);
      cxa_type r;
      r = z;
      case (code)
         ROT_PI: begin
            r.re = -z.im;
            r.im = z.re;
         end
         ROT_M1: begin
            r.re = -z.re;
            r.im = -z.im;
         end
         ROT_MI: begin
            r.re = z.im;
            r.im = -z.re;
         end
         default: r = z;
      endcase
      return r;
   endfunction

   // rotation applied to the lower component before the sum
   function automatic logic [1:0] proj_q(input logic m, input logic [1:0] d);
      logic [1:0] c;
      case ({m, d})
         3'b000:  c = ROT_M1;
         3'b001:  c = ROT_PI;
         3'b010:  c = ROT_P1;
         3'b011:  c = ROT_MI;
         3'b100:  c = ROT_P1;
         3'b101:  c = ROT_MI;
         3'b110:  c = ROT_M1;
         default: c = ROT_PI;
      endcase
      return c;
   endfunction

   // rotation that forms the lower result component
   function automatic logic [1:0] proj_k(input logic m, input logic [1:0] d);
      logic [1:0] c;
      case ({m, d})
         3'b000:  c = ROT_M1;
         3'b001:  c = ROT_MI;
         3'b010:  c = ROT_P1;
         3'b011:  c = ROT_PI;
         3'b100:  c = ROT_P1;
         3'b101:  c = ROT_PI;
         3'b110:  c = ROT_M1;
         default: c = ROT_MI;
      endcase
      return c;
   endfunction

   function automatic cxo_type mk(input logic [wds_pkg::CPLX_W-1:0] w, input logic conj);
      cxo_type z;
      z.re = OP_W'($signed(w[wds_pkg::DATA_W-1:0]));
      z.im = OP_W'($signed(w[wds_pkg::CPLX_W-1:wds_pkg::DATA_W]));
      if (conj) begin
         z.im = -z.im;
      end
      return z;
   endfunction

   function automatic fin_type finish(input logic signed [ACC_W-1:0] m,
                                      input logic signed [ACC_W-1:0] h);
      logic signed [ACC_W-1:0] tsum;
      logic signed [V_W-1:0]   v;
      fin_type                 f;
      tsum = (m <<< 1) - h + RND;
      v    = tsum[ACC_W-1:17];
      if (v > V_MAX) begin
         f.sat = 1'b1;
         f.val = 32'sh7fffffff;
      end else if (v < V_MIN) begin
         f.sat = 1'b1;
         f.val = 32'sh80000000;
      end else begin
         f.sat = 1'b0;
         f.val = v[wds_pkg::DATA_W-1:0];
      end
      return f;
   endfunction

   state_type                       state_ff;
   logic [3:0]                      cnt_ff;
   wds_pkg::job_type                job_ff;
   cxo_type                         lnk_ff [wds_pkg::NB_NUM];
   logic [wds_pkg::CPLX_W-1:0]      up_ff  [SPIN_N];
   logic [wds_pkg::CPLX_W-1:0]      dn_ff  [SPIN_N];
   logic [wds_pkg::SIGN_W-1:0]      sign_ff;
   logic signed [PROD_W-1:0]        prod_ff [4];
   logic signed [PROD_W-1:0]        prod_in [4];
   logic [3:0]                      prod_k_ff;
   logic                            prod_vld_ff;
   cxa_type                         p0_ff;
   cxa_type                         h0_ff;
   cxa_type                         h1_ff;
   logic signed [ACC_W-1:0]         m_up_re_ff;
   logic signed [ACC_W-1:0]         m_up_im_ff;
   logic signed [ACC_W-1:0]         m_dn_re_ff;
   logic signed [ACC_W-1:0]         m_dn_im_ff;
   logic                            rsp_valid_ff;
   wds_pkg::rsp_type                rsp_data_ff;

   logic                            ram_we;
   logic [AW-1:0]                   lt_addr;
   logic [AW-1:0]                   lx_addr;
   logic [AW-1:0]                   sp_addr;
   logic [AW-1:0]                   site_a;
   logic [wds_pkg::CPLX_W-1:0]      lt_rd;
   logic [wds_pkg::CPLX_W-1:0]      lx_rd;
   logic [wds_pkg::CPLX_W-1:0]      up_rd;
   logic [wds_pkg::CPLX_W-1:0]      dn_rd;
   logic [wds_pkg::SIGN_W-1:0]      sg_rd;
   logic [SP_W-1:0]                 cap_idx;

   logic signed [OP_W-1:0]          opa [4];
   logic signed [OP_W-1:0]          opb [4];
   logic signed [FULL_W-1:0]        full [4];
   logic signed [OP_W-1:0]          mfac;
   logic [SP_W-1:0]                 sp_idx;
   logic [wds_pkg::CPLX_W-1:0]      sp_word;
   cxo_type                         sp_cx;
   cxo_type                         l_cx;

   cxa_type                         cp;
   cxa_type                         qv;
   cxa_type                         wv;
   cxa_type                         hk;
   logic [1:0]                      kd;
   fin_type                         f_ur;
   fin_type                         f_ui;
   fin_type                         f_dr;
   fin_type                         f_di;
   logic                            out_free;

   // memory ports
   assign site_a  = job_ff.item.site;
   assign ram_we  = (state_ff == B_LOAD);
   assign lt_addr = (state_ff == B_FETCH && cnt_ff == 4'd1) ? job_ff.nb[2] : site_a;
   assign lx_addr = (state_ff == B_FETCH && cnt_ff == 4'd1) ? job_ff.nb[3] : site_a;
   assign sp_addr = (state_ff == B_FETCH && cnt_ff < 4'd4) ? job_ff.nb[cnt_ff[1:0]] : site_a;
   assign cap_idx = SP_W'(cnt_ff - 4'd1);

   wds_ram #(.WIDTH(wds_pkg::CPLX_W), .DEPTH(wds_pkg::MEM_DEPTH)) u_link_t_mem (
      .clock (clock),
      .we    (ram_we),
      .addr  (lt_addr),
      .wdata ({job_ff.item.link_t_im, job_ff.item.link_t_re}),
      .rdata (lt_rd)
   );

   wds_ram #(.WIDTH(wds_pkg::CPLX_W), .DEPTH(wds_pkg::MEM_DEPTH)) u_link_x_mem (
      .clock (clock),
      .we    (ram_we),
      .addr  (lx_addr),
      .wdata ({job_ff.item.link_x_im, job_ff.item.link_x_re}),
      .rdata (lx_rd)
   );

   wds_ram #(.WIDTH(wds_pkg::CPLX_W), .DEPTH(wds_pkg::MEM_DEPTH)) u_spin_up_mem (
      .clock (clock),
      .we    (ram_we),
      .addr  (sp_addr),
      .wdata ({job_ff.item.up_im, job_ff.item.up_re}),
      .rdata (up_rd)
   );

   wds_ram #(.WIDTH(wds_pkg::CPLX_W), .DEPTH(wds_pkg::MEM_DEPTH)) u_spin_down_mem (
      .clock (clock),
      .we    (ram_we),
      .addr  (sp_addr),
      .wdata ({job_ff.item.down_im, job_ff.item.down_re}),
      .rdata (dn_rd)
   );

   wds_ram #(.WIDTH(wds_pkg::SIGN_W), .DEPTH(wds_pkg::MEM_DEPTH)) u_sign_mem (
      .clock (clock),
      .we    (ram_we),
      .addr  (site_a),
      .wdata (job_ff.item.hop_signs),
      .rdata (sg_rd)
   );

   // multiply operands: eight link-spinor products, then two mass products
   assign mfac = OP_W'(mass) + TWO_Q;

   always_comb begin
      sp_idx  = (cnt_ff >= 4'd8) ? SP_W'(4) : SP_W'(cnt_ff[2:1]);
      sp_word = cnt_ff[0] ? dn_ff[sp_idx] : up_ff[sp_idx];
      sp_cx   = mk(sp_word, 1'b0);
      l_cx    = lnk_ff[cnt_ff[2:1]];
      if (cnt_ff >= 4'd8) begin
         opa[0] = mfac;
         opb[0] = sp_cx.re;
         opa[1] = mfac;
         opb[1] = sp_cx.im;
         opa[2] = '0;
         opb[2] = '0;
         opa[3] = '0;
         opb[3] = '0;
      end else begin
         opa[0] = l_cx.re;
         opb[0] = sp_cx.re;
         opa[1] = l_cx.im;
         opb[1] = sp_cx.im;
         opa[2] = l_cx.re;
         opb[2] = sp_cx.im;
         opa[3] = l_cx.im;
         opb[3] = sp_cx.re;
      end
      for (int i = 0; i < 4; i++) begin
         full[i]    = FULL_W'(opa[i]) * FULL_W'(opb[i]);
         prod_in[i] = full[i][PROD_W+7:8];
      end
   end

   // accumulate one direction once both products are in
   always_comb begin
      kd    = prod_k_ff[2:1];
      cp.re = ACC_W'(prod_ff[0]) - ACC_W'(prod_ff[1]);
      cp.im = ACC_W'(prod_ff[2]) + ACC_W'(prod_ff[3]);
      qv    = rot(cp, proj_q(mode, kd));
      wv.re = p0_ff.re + qv.re;
      wv.im = p0_ff.im + qv.im;
      if (sign_ff[kd]) begin
         wv.re = -wv.re;
         wv.im = -wv.im;
      end
      hk = rot(wv, proj_k(mode, kd));
   end

   assign f_ur     = finish(m_up_re_ff, h0_ff.re);
   assign f_ui     = finish(m_up_im_ff, h0_ff.im);
   assign f_dr     = finish(m_dn_re_ff, h1_ff.re);
   assign f_di     = finish(m_dn_im_ff, h1_ff.im);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_vld_ff <= (state_ff == B_MUL) && (cnt_ff < 4'(MUL_STEPS));
         prod_k_ff   <= cnt_ff;
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         if (prod_vld_ff) begin
            if (prod_k_ff == 4'd8) begin
               m_up_re_ff <= ACC_W'(prod_ff[0]);
               m_up_im_ff <= ACC_W'(prod_ff[1]);
            end else if (prod_k_ff == 4'd9) begin
               m_dn_re_ff <= ACC_W'(prod_ff[0]);
               m_dn_im_ff <= ACC_W'(prod_ff[1]);
            end else if (!prod_k_ff[0]) begin
               p0_ff <= cp;
            end else begin
               h0_ff.re <= h0_ff.re + wv.re;
               h0_ff.im <= h0_ff.im + wv.im;
               h1_ff.re <= h1_ff.re + hk.re;
               h1_ff.im <= h1_ff.im + hk.im;
            end
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != B_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               cnt_ff <= '0;
               h0_ff  <= '0;
               h1_ff  <= '0;
               if (!q_empty) begin
                  job_ff   <= q_data;
                  state_ff <= (q_data.item.cmd == wds_pkg::CMD_LOAD) ? B_LOAD : B_FETCH;
               end
            end
            B_LOAD: begin
               state_ff <= B_IDLE;
            end
            B_FETCH: begin
               if (cnt_ff != '0) begin
                  up_ff[cap_idx] <= up_rd;
                  dn_ff[cap_idx] <= dn_rd;
               end
               if (cnt_ff == 4'd1) begin
                  lnk_ff[0] <= mk(lt_rd, 1'b0);
                  lnk_ff[1] <= mk(lx_rd, 1'b0);
                  sign_ff   <= sg_rd;
               end
               if (cnt_ff == 4'd2) begin
                  lnk_ff[2] <= mk(lt_rd, 1'b1);
                  lnk_ff[3] <= mk(lx_rd, 1'b1);
               end
               if (cnt_ff == 4'(FETCH_STEPS)) begin
                  cnt_ff   <= '0;
                  state_ff <= B_MUL;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            B_MUL: begin
               if (cnt_ff == 4'(MUL_STEPS)) begin
                  cnt_ff   <= '0;
                  state_ff <= B_FIN;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            B_FIN: begin
               if (out_free) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.out_site     <= job_ff.item.site;
                  rsp_data_ff.res_up_re    <= f_ur.val;
                  rsp_data_ff.res_up_im    <= f_ui.val;
                  rsp_data_ff.res_down_re  <= f_dr.val;
                  rsp_data_ff.res_down_im  <= f_di.val;
                  rsp_data_ff.saturated    <= f_ur.sat | f_ui.sat | f_dr.sat | f_di.sat;
                  state_ff                 <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/wilson_dirac_stencil_2d_core.sv =====
// ----------------------------------------------------------------------------
// wilson_dirac_stencil_2d_core
// wilson dirac operator on a periodic 2d lattice, signed q8.24 data
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid, req_stall, req_data) carries load and compute
//   beats. a load beat writes one site's links, spinor and hop signs; a compute
//   beat returns one rsp beat with the result for that site. sites at or beyond
//   LATTICE_X*LATTICE_T are dropped and give no rsp beat. the user must write
//   csr mass (index 0) and operator mode (index 1) while idle; not enforced.
// timing
//   the front classifies a beat through its divide and modulo states, then
//   pushes the job; it takes no new beat until the push is done. a load
//   holds the back for the pop and the memory write. a compute in the back
//   takes the job, runs the memory fetches over the single-port site rams,
//   forms the complex products through one multiplier bank, then rounds.
//   the back takes no new job until it has rounded the last, so the back
//   sequence sets the sustained compute rate.
// reset and stall
//   reset empties the queue and all control; mass and mode return to 0;
//   site memory contents are undefined until loaded. a stalled rsp beat
//   holds, the back waits in its rounding step and the queue fills, then
//   req_stall stays high until space frees.
// ----------------------------------------------------------------------------
module wilson_dirac_stencil_2d_core #(
   parameter int LATTICE_X = wds_pkg::LATTICE_X_DEF,
   parameter int LATTICE_T = wds_pkg::LATTICE_T_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  wds_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output wds_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [wds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wds_pkg::DATA_W-1:0]      csr_wdata
);

   logic signed [wds_pkg::DATA_W-1:0] mass_ff;
   logic                              mode_ff;
   logic                              q_push;
   logic                              q_full;
   logic                              q_pop;
   logic                              q_empty;
   wds_pkg::job_type                  q_in;
   wds_pkg::job_type                  q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= '0;
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            wds_pkg::CSR_MASS: mass_ff <= csr_wdata;
            wds_pkg::CSR_MODE: mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   wds_front #(.LATTICE_X(LATTICE_X), .LATTICE_T(LATTICE_T)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_data    (q_in)
   );

   wds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_in),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   wds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_out),
      .mass      (mass_ff),
      .mode      (mode_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job queue pushed while full");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job queue popped while empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the 2d wilson dirac stencil: loads the lattice,
// runs directed and random compute beats under both operator modes and
// several masses, and checks every rsp beat against an in-bench predictor
// ----------------------------------------------------------------------------
module tb;

   localparam int NX        = wds_pkg::LATTICE_X_DEF;
   localparam int NT        = wds_pkg::LATTICE_T_DEF;
   localparam int NSITES    = NX * NT;
   localparam int IDLE_LIM  = 20000;
   localparam int TAIL_CYC  = 60;
   localparam int PHASE_N   = 31;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   wds_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   wds_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [wds_pkg::CSR_IDX_W-1:0] csr_index;
   logic [wds_pkg::DATA_W-1:0] csr_wdata;

   wilson_dirac_stencil_2d_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // predictor state
   logic [63:0] lt_store [NSITES];
   logic [63:0] lx_store [NSITES];
   logic [63:0] su_store [NSITES];
   logic [63:0] sd_store [NSITES];
   logic [3:0]  sg_store [NSITES];
   bit          loaded [NSITES];
   logic signed [31:0] cur_mass;
   logic cur_mode;

   wds_pkg::req_type pending_beats [$];
   wds_pkg::rsp_type expected_rsp [$];
   int mismatches;
   int unmatched;
   int rsp_seen;
   int idle_cycles;
   bit running;
   bit req_taken;

   typedef struct { longint re; longint im; } cplx_type;

   function automatic longint floor_shr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint mul_q40(longint a, longint b);
      return floor_shr(a * b, 8);
   endfunction

   function automatic cplx_type unpack_cx(logic [63:0] w);
      cplx_type z;
      z.re = longint'($signed(w[31:0]));
      z.im = longint'($signed(w[63:32]));
      return z;
   endfunction

   function automatic cplx_type rotate(cplx_type z, int code);
      cplx_type r;
      r = z;
      case (code)
         1: begin r.re = -z.im; r.im = z.re; end
         2: begin r.re = -z.re; r.im = -z.im; end
         3: begin r.re = z.im;  r.im = -z.re; end
         default: ;
      endcase
      return r;
   endfunction

   function automatic cplx_type cmul(cplx_type l, cplx_type a);
      cplx_type r;
      r.re = mul_q40(l.re, a.re) - mul_q40(l.im, a.im);
      r.im = mul_q40(l.re, a.im) + mul_q40(l.im, a.re);
      return r;
   endfunction

   function automatic logic [31:0] round_sat(longint m40, longint h40, ref bit sat);
      longint v;
      v = floor_shr(2 * m40 - h40 + 65536, 17);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // projector codes per mode and direction: a1 factor, then k
   function automatic int proj_code(logic mode, int d, int which);
      int tab0 [4][2] = '{'{2, 2}, '{1, 3}, '{0, 0}, '{3, 1}};
      int tab1 [4][2] = '{'{0, 0}, '{3, 1}, '{2, 2}, '{1, 3}};
      return mode ? tab1[d][which] : tab0[d][which];
   endfunction

   function automatic void stencil_apply(wds_pkg::req_type b);
      int s, x, t, d;
      int nb [4];
      cplx_type lnk [4];
      cplx_type h0, h1, w, p0, p1, q;
      longint mfac;
      bit sat;
      wds_pkg::rsp_type r;
      s = b.site;
      sat = 1'b0;
      if (s >= NSITES) return;
      if (b.cmd == wds_pkg::CMD_LOAD) begin
         lt_store[s] = {b.link_t_im, b.link_t_re};
         lx_store[s] = {b.link_x_im, b.link_x_re};
         su_store[s] = {b.up_im, b.up_re};
         sd_store[s] = {b.down_im, b.down_re};
         sg_store[s] = b.hop_signs;
         loaded[s] = 1'b1;
         return;
      end
      x = s / NT;
      t = s % NT;
      nb[0] = x * NT + (t + 1) % NT;
      nb[1] = ((x + 1) % NX) * NT + t;
      nb[2] = x * NT + (t + NT - 1) % NT;
      nb[3] = ((x + NX - 1) % NX) * NT + t;
      lnk[0] = unpack_cx(lt_store[s]);
      lnk[1] = unpack_cx(lx_store[s]);
      lnk[2] = unpack_cx(lt_store[nb[2]]);
      lnk[2].im = -lnk[2].im;
      lnk[3] = unpack_cx(lx_store[nb[3]]);
      lnk[3].im = -lnk[3].im;
      h0 = '{0, 0};
      h1 = '{0, 0};
      for (d = 0; d < 4; d++) begin
         p0 = cmul(lnk[d], unpack_cx(su_store[nb[d]]));
         p1 = cmul(lnk[d], unpack_cx(sd_store[nb[d]]));
         q = rotate(p1, proj_code(cur_mode, d, 0));
         w.re = p0.re + q.re;
         w.im = p0.im + q.im;
         if (sg_store[s][d]) begin
            w.re = -w.re;
            w.im = -w.im;
         end
         h0.re += w.re;
         h0.im += w.im;
         q = rotate(w, proj_code(cur_mode, d, 1));
         h1.re += q.re;
         h1.im += q.im;
      end
      mfac = longint'(cur_mass) + 2 * 64'sd16777216;
      p0 = unpack_cx(su_store[s]);
      p1 = unpack_cx(sd_store[s]);
      r.out_site = b.site;
      r.res_up_re = round_sat(mul_q40(mfac, p0.re), h0.re, sat);
      r.res_up_im = round_sat(mul_q40(mfac, p0.im), h0.im, sat);
      r.res_down_re = round_sat(mul_q40(mfac, p1.re), h1.re, sat);
      r.res_down_im = round_sat(mul_q40(mfac, p1.im), h1.im, sat);
      r.saturated = sat;
      expected_rsp.push_back(r);
   endfunction

   // beat taken at the last rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
      end
   end

   // driver: bursts with random gaps
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_taken) begin
         if (req_valid) void'(pending_beats.pop_front());
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_data <= pending_beats[0];
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(30, 1);
               gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(25, 0);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   int stall_mode;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(200, 0) == 0) stall_mode <= $urandom_range(3, 0);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3, 0) == 0);
            2: rsp_stall <= ($urandom_range(1, 0) == 0);
            default: rsp_stall <= ($urandom_range(9, 0) != 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) stencil_apply(req_data);
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsp.size() == 0) begin
               unmatched <= unmatched + 1;
               if (mismatches + unmatched < 10)
                  $display("unexpected rsp beat site %0d", rsp_data.out_site);
            end else begin
               if (rsp_data !== expected_rsp[0]) begin
                  if (mismatches + unmatched < 10) begin
                     $display("mismatch: exp site %0d %h %h %h %h sat %b",
                        expected_rsp[0].out_site, expected_rsp[0].res_up_re,
                        expected_rsp[0].res_up_im, expected_rsp[0].res_down_re,
                        expected_rsp[0].res_down_im, expected_rsp[0].saturated);
                     $display("          got site %0d %h %h %h %h sat %b",
                        rsp_data.out_site, rsp_data.res_up_re, rsp_data.res_up_im,
                        rsp_data.res_down_re, rsp_data.res_down_im, rsp_data.saturated);
                  end
                  mismatches <= mismatches + 1;
               end
               void'(expected_rsp.pop_front());
            end
         end
         if (running && !(req_valid && !req_stall) && !(rsp_valid && !rsp_stall)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIM) begin
               $display("watchdog: no beat for %0d cycles", IDLE_LIM);
               $display("Regression FAIL");
               $finish;
            end
         end else begin
            idle_cycles <= 0;
         end
      end
   end

   function automatic logic [31:0] rand_q(int kind);
      case (kind)
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return $signed($urandom_range(32'h02000000, 0)) - 32'sh01000000;
      endcase
   endfunction

   function automatic wds_pkg::req_type load_beat(int s, int kind);
      wds_pkg::req_type b;
      b.cmd = wds_pkg::CMD_LOAD;
      b.site = wds_pkg::SITE_W'(s);
      b.link_t_re = rand_q(kind);
      b.link_t_im = rand_q(kind == 0 ? 1 : kind);
      b.link_x_re = rand_q(kind);
      b.link_x_im = rand_q(kind);
      b.up_re = rand_q(kind);
      b.up_im = rand_q(kind == 1 ? 0 : kind);
      b.down_re = rand_q(kind);
      b.down_im = rand_q(kind);
      b.hop_signs = wds_pkg::SIGN_W'($urandom);
      return b;
   endfunction

   function automatic wds_pkg::req_type compute_beat(int s);
      wds_pkg::req_type b;
      b = load_beat(0, 2);
      b.cmd = wds_pkg::CMD_COMPUTE;
      b.site = wds_pkg::SITE_W'(s);
      return b;
   endfunction

   task automatic settle();
      while (pending_beats.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYC) @(posedge clock);
   endtask

   task automatic write_csr(logic [wds_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == wds_pkg::CSR_MASS) cur_mass = val;
      else cur_mode = val[0];
   endtask

   initial begin
      int i, ph, n_comp;
      logic [31:0] masses [5];
      masses = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'hff000000, 32'h00800000};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      unmatched = 0;
      rsp_seen = 0;
      idle_cycles = 0;
      running = 1'b0;
      cur_mass = 0;
      cur_mode = 1'b0;
      n_comp = 0;
      for (i = 0; i < NSITES; i++) loaded[i] = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      running = 1'b1;
      // directed: corner and extreme loads, computes at wrap corners
      for (i = 0; i < NSITES; i++) pending_beats.push_back(load_beat(i, 3));
      pending_beats.push_back(load_beat(0, 0));
      pending_beats.push_back(load_beat(1, 1));
      pending_beats.push_back(load_beat(NT, 0));
      pending_beats.push_back(load_beat(NSITES - 1, 1));
      pending_beats.push_back(load_beat(NT - 1, 0));
      pending_beats.push_back(load_beat(NSITES, 0));
      pending_beats.push_back(load_beat(1023, 1));
      pending_beats.push_back(compute_beat(0));
      pending_beats.push_back(compute_beat(NT - 1));
      pending_beats.push_back(compute_beat(NSITES - 1));
      pending_beats.push_back(compute_beat(NSITES - NT));
      pending_beats.push_back(compute_beat(1));
      pending_beats.push_back(compute_beat(NT));
      pending_beats.push_back(compute_beat(1023));
      n_comp = n_comp + 7;
      settle();
      // random phases over mode and mass settings
      for (ph = 0; ph < 10; ph++) begin
         write_csr(wds_pkg::CSR_MODE, {31'b0, ph[0]});
         write_csr(wds_pkg::CSR_MASS, (ph < 5) ? masses[ph] : masses[ph - 5]);
         for (i = 0; i < PHASE_N; i++) begin
            case ($urandom_range(9, 0))
               0, 1, 2: pending_beats.push_back(load_beat($urandom_range(NSITES - 1, 0),
                                                          $urandom_range(3, 0)));
               3: pending_beats.push_back(($urandom_range(1, 0) == 0) ?
                     load_beat($urandom_range(1023, NSITES), 2) :
                     compute_beat($urandom_range(1023, NSITES)));
               default: pending_beats.push_back(compute_beat($urandom_range(NSITES - 1, 0)));
            endcase
         end
         n_comp = n_comp + PHASE_N;
         settle();
      end
      running = 1'b0;
      $display("covered %0d rsp beats over 10 mass/mode settings, both operator modes",
               rsp_seen);
      $display("mismatches %0d, unexpected beats %0d, leftover %0d",
               mismatches, unmatched, expected_rsp.size());
      if (mismatches == 0 && unmatched == 0 && expected_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
